// ===== rtl/ledsw_pkg.sv =====
// Package for the LED driver shift-word generator.
// Types, constants and word-forming functions; no dependencies.
package ledsw_pkg;

	localparam int PIXELS_PER_FRAME  = 16;
	localparam int WORD_BITS         = 48;
	localparam int POKER_PLANES      = 9;
	localparam int NORMAL_COLOR_BITS = 8;

	localparam int COLOR_W     = 9;
	localparam int COLORS      = 3;
	localparam int COLOR_SLOT  = 16;
	localparam int STORE_DEPTH = 16;
	localparam int ADDR_W      = 4;
	localparam int PLANE_W     = (POKER_PLANES > 1) ? $clog2(POKER_PLANES) : 1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [PLANE_W-1:0]   plane_t;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} pixel_t;

	localparam logic [1:0] MODE_CONFIG = 2'd0;
	localparam logic [1:0] MODE_ENABLE = 2'd1;
	localparam logic [1:0] MODE_NORMAL = 2'd2;
	localparam logic [1:0] MODE_POKER  = 2'd3;

	localparam logic [5:0] CNT_WORD   = 6'd48;
	localparam logic [5:0] CNT_ENABLE = 6'd15;
	localparam logic [3:0] LAT_WRITE  = 4'd1;
	localparam logic [3:0] LAT_FRAME  = 4'd3;
	localparam logic [3:0] LAT_CONFIG = 4'd5;
	localparam logic [3:0] LAT_ENABLE = 4'd15;

	localparam addr_t  LAST_POS   = ADDR_W'(PIXELS_PER_FRAME - 1);
	localparam addr_t  LAST_ADDR  = ADDR_W'(STORE_DEPTH - 1);
	localparam plane_t LAST_PLANE = PLANE_W'(POKER_PLANES - 1);

	typedef struct packed {
		logic   en;
		addr_t  addr;
		pixel_t data;
	} px_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} px_rd_t;

	typedef struct packed {
		logic   start;
		plane_t plane;
	} plane_ctrl_t;

	function automatic word_t reverse_word(word_t w);
		word_t r;
		for (int i = 0; i < WORD_BITS; i++) begin
			r[WORD_BITS-1-i] = w[i];
		end
		return r;
	endfunction

	// colour c in bits 16c..16c+15, low color bits sent MSB first
	function automatic word_t normal_word(pixel_t px);
		word_t              w;
		logic [COLOR_W-1:0] v;
		int                 b;
		w = '0;
		for (int c = 0; c < COLORS; c++) begin
			v = px[COLOR_W*c +: COLOR_W];
			for (int j = 0; j < COLOR_SLOT; j++) begin
				b = NORMAL_COLOR_BITS - 1 - j;
				if (j < NORMAL_COLOR_BITS && b >= 0 && b < COLOR_W) begin
					w[c*COLOR_SLOT + j] = v[b];
				end
			end
		end
		return w;
	endfunction

endpackage

// ===== rtl/ledsw_if.sv =====
// Valid/ready channel interfaces for the shift-word generator.
// No dependencies.
interface ledsw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [8:0] red;
	logic [8:0] green;
	logic [8:0] blue;

	modport source (output valid, mode, red, green, blue, input ready);
	modport sink   (input valid, mode, red, green, blue, output ready);
endinterface

interface ledsw_word_if;
	logic        valid;
	logic        ready;
	logic [47:0] serial_bits;
	logic [5:0]  bit_count;
	logic [3:0]  latch_clocks;
	logic        last;

	modport source (output valid, serial_bits, bit_count, latch_clocks, last, input ready);
	modport sink   (input valid, serial_bits, bit_count, latch_clocks, last, output ready);
endinterface

// ===== rtl/ledsw_pixel_store.sv =====
// Frame pixel memory: one write port, one registered read port.
// Depends on ledsw_pkg.
module ledsw_pixel_store (
	input  logic              clk,
	input  ledsw_pkg::px_wr_t wr,
	input  ledsw_pkg::px_rd_t rd,
	output ledsw_pkg::pixel_t rd_data
);
	import ledsw_pkg::*;

	pixel_t mem_q [STORE_DEPTH];
	pixel_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/ledsw_plane_shifter.sv =====
// Bit-plane assembler: reads one pixel a cycle and shifts its three
// plane bits into a 48-bit word. Depends on ledsw_pkg.
module ledsw_plane_shifter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ledsw_pkg::plane_ctrl_t ctrl,
	output ledsw_pkg::px_rd_t      rd,
	input  ledsw_pkg::pixel_t      rd_data,
	output ledsw_pkg::word_t       word,
	output logic                   done
);
	import ledsw_pkg::*;

	logic   busy_q;
	addr_t  iss_q;
	plane_t plane_q;
	logic   vld_s1;
	logic   last_s1;
	addr_t  addr_s1;
	logic   done_q;
	word_t  word_q;

	logic [COLORS-1:0]  digit;
	logic [COLOR_W-1:0] col;
	logic               keep;

	assign rd.en   = busy_q;
	assign rd.addr = iss_q;

	assign keep = {1'b0, addr_s1} < (ADDR_W+1)'(PIXELS_PER_FRAME);

	// colour 0 lands on the highest bit of the three
	always_comb begin
		digit = '0;
		col   = '0;
		for (int c = 0; c < COLORS; c++) begin
			col = rd_data[COLOR_W*c +: COLOR_W];
			digit[COLORS-1-c] = col[plane_q] & keep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			iss_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (ctrl.start) begin
				busy_q <= 1'b1;
				iss_q  <= '0;
			end else if (busy_q) begin
				iss_q <= iss_q + 1'b1;
				if (iss_q == LAST_ADDR) begin
					busy_q <= 1'b0;
				end
			end
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (iss_q == LAST_ADDR);
			done_q  <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			plane_q <= ctrl.plane;
		end
		addr_s1 <= iss_q;
		if (vld_s1) begin
			word_q <= {word_q[WORD_BITS-COLORS-1:0], digit};
		end
	end

	assign word = word_q;
	assign done = done_q;

endmodule

// ===== rtl/led_driver_shift_word_generator.sv =====
// Top level of the LED driver shift-word generator.
// Depends on ledsw_pkg, ledsw_if, ledsw_pixel_store, ledsw_plane_shifter.
//
// channel  dir  handshake      payload
// cmd      in   valid/ready    mode, red, green, blue
// word     out  valid/ready    serial_bits, bit_count, latch_clocks, last
// cfg      in   cfg_we         cfg_wdata (function control word)
//
// Config, enable and normal items pass through ST_WORD; a poker pixel that does
// not end a frame is only stored. A frame-ending poker pixel yields 9 plane
// words, each from 16 pixel reads through the single memory read port, a
// registered read, the done flag and a load of the output register; no command
// is taken until the last one is loaded. Output stalls hold the machine only
// when a new word is ready to load. Reset clears control, not the pixel memory.
module led_driver_shift_word_generator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [47:0]            cfg_wdata,
	ledsw_cmd_if.sink              cmd,
	ledsw_word_if.source           word
);
	import ledsw_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WORD  = 4'b0010,
		ST_PLANE = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t      state_q;
	word_t       fc_q;
	addr_t       pix_cnt_q;
	logic [1:0]  mode_q;
	pixel_t      px_q;
	logic        frame_end_q;
	plane_t      plane_q;

	logic        out_valid_q;
	word_t       serial_bits_q;
	logic [5:0]  bit_count_q;
	logic [3:0]  latch_clocks_q;
	logic        last_q;

	logic        accept;
	logic        slot_free;
	logic        frame_end;
	logic        fin;
	logic        load_word;
	logic        load_plane;
	pixel_t      px_in;
	px_wr_t      wr;
	px_rd_t      rd;
	pixel_t      rd_data;
	plane_ctrl_t pctl;
	word_t       plane_word;
	logic        plane_done;

	assign px_in     = '{blue: cmd.blue, green: cmd.green, red: cmd.red};
	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !out_valid_q || word.ready;
	assign frame_end = (pix_cnt_q >= LAST_POS);
	assign fin       = (plane_q == LAST_PLANE);

	assign load_word  = (state_q == ST_WORD) && slot_free;
	assign load_plane = (state_q == ST_EMIT) && slot_free;

	assign wr.en   = accept && (cmd.mode == MODE_POKER);
	assign wr.addr = pix_cnt_q;
	assign wr.data = px_in;

	always_comb begin
		pctl.start = 1'b0;
		pctl.plane = '0;
		if (accept && (cmd.mode == MODE_POKER) && frame_end) begin
			pctl.start = 1'b1;
		end else if (load_plane && !fin) begin
			pctl.start = 1'b1;
			pctl.plane = plane_q + 1'b1;
		end
	end

	ledsw_pixel_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	ledsw_plane_shifter u_shift (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (pctl),
		.rd      (rd),
		.rd_data (rd_data),
		.word    (plane_word),
		.done    (plane_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fc_q        <= '0;
			pix_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fc_q <= cfg_wdata;
			end
			if (accept && (cmd.mode == MODE_NORMAL || cmd.mode == MODE_POKER)) begin
				pix_cnt_q <= frame_end ? '0 : pix_cnt_q + 1'b1;
			end
			if (load_word || load_plane) begin
				out_valid_q <= 1'b1;
			end else if (word.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.mode != MODE_POKER) begin
							state_q <= ST_WORD;
						end else if (frame_end) begin
							state_q <= ST_PLANE;
						end
					end
				end
				ST_WORD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PLANE: begin
					if (plane_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= fin ? ST_IDLE : ST_PLANE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= cmd.mode;
			px_q        <= px_in;
			frame_end_q <= frame_end;
		end
		if (pctl.start) begin
			plane_q <= pctl.plane;
		end
		if (load_word) begin
			last_q <= 1'b1;
			unique case (mode_q)
				MODE_CONFIG: begin
					serial_bits_q  <= reverse_word(fc_q);
					bit_count_q    <= CNT_WORD;
					latch_clocks_q <= LAT_CONFIG;
				end
				MODE_ENABLE: begin
					serial_bits_q  <= '0;
					bit_count_q    <= CNT_ENABLE;
					latch_clocks_q <= LAT_ENABLE;
				end
				default: begin
					serial_bits_q  <= normal_word(px_q);
					bit_count_q    <= CNT_WORD;
					latch_clocks_q <= frame_end_q ? LAT_FRAME : LAT_WRITE;
				end
			endcase
		end else if (load_plane) begin
			serial_bits_q  <= plane_word;
			bit_count_q    <= CNT_WORD;
			latch_clocks_q <= fin ? LAT_FRAME : LAT_WRITE;
			last_q         <= fin;
		end
	end

	assign word.valid        = out_valid_q;
	assign word.serial_bits  = serial_bits_q;
	assign word.bit_count    = bit_count_q;
	assign word.latch_clocks = latch_clocks_q;
	assign word.last         = last_q;

endmodule

// ===== rtl/ledsw_checker.sv =====
// Port-level checks for the shift-word generator, bound to the top level.
// Depends on the top level's port list only.
module ledsw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] serial_bits,
	input logic [5:0]  bit_count,
	input logic [3:0]  latch_clocks,
	input logic        last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(serial_bits) && $stable(last))
		else $error("output item changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bit_count == 6'd48 || bit_count == 6'd15))
		else $error("bad bit count");

	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_count == 6'd15 |-> latch_clocks == 4'd15 && serial_bits == '0
		&& last)
		else $error("bad enable word");

	a_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> latch_clocks == 4'd1 && bit_count == 6'd48)
		else $error("bad inner plane word");

endmodule

bind led_driver_shift_word_generator ledsw_checker u_ledsw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (word.valid),
	.out_ready    (word.ready),
	.serial_bits  (word.serial_bits),
	.bit_count    (word.bit_count),
	.latch_clocks (word.latch_clocks),
	.last         (word.last)
);
